>>> rtl/pcb_pkg.sv
// Shared types, register indexes and helpers for the point-to-cell binning block.
package pcb_pkg;

	localparam int unsigned POS_W   = 32;
	localparam int unsigned CELL_W  = 10;
	localparam int unsigned LIN_W   = 30;
	localparam int unsigned HALO_W  = 4;
	localparam int unsigned DIMS_W  = 30;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned LIMIT_W = 13;
	localparam int unsigned ITEM_W  = 3 * POS_W;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [IDX_W-1:0] REG_INV_LEN_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_INV_LEN_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_INV_LEN_Z = 3'd5;
	localparam logic [IDX_W-1:0] REG_GRID_DIMS = 3'd6;
	localparam logic [IDX_W-1:0] REG_HALO      = 3'd7;

	// Register reset values
	localparam logic [POS_W-1:0]  RST_ORIGIN = 32'd0;
	localparam logic [POS_W-1:0]  RST_INV    = 32'd65536;
	localparam logic [DIMS_W-1:0] RST_DIMS   = 30'd3148803;
	localparam logic [HALO_W-1:0] RST_HALO   = 4'd1;

	// Per-stage advance enables shared by all pipeline modules
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// Cells on one axis: zero counts as one cell, limited to the grid maximum
	function automatic logic [CELL_W-1:0] axis_count(input logic [CELL_W-1:0] field,
			input logic [LIMIT_W-1:0] limit);
		logic [CELL_W-1:0] n;
		begin
			n = (field == '0) ? CELL_W'(1) : field;
			if ({3'b000, n} > limit) begin
				n = limit[CELL_W-1:0];
			end
			return n;
		end
	endfunction

endpackage

>>> rtl/pcb_skid.sv
// Input skid buffer: registered stall toward the producer.
module pcb_skid (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pcb_pkg::ITEM_W-1:0] in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pcb_pkg::ITEM_W-1:0] out_data
);

	logic                       full_q;
	logic [pcb_pkg::ITEM_W-1:0] buf_q;

	assign in_stall  = full_q;
	assign out_valid = full_q | in_valid;
	assign out_data  = full_q ? buf_q : in_data;

	// Park an offered item when the pipeline holds, release it when it moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (full_q) begin
			if (!out_stall) begin
				full_q <= 1'b0;
			end
		end else if (in_valid && out_stall) begin
			full_q <= 1'b1;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (!full_q && in_valid && out_stall) begin
			buf_q <= in_data;
		end
	end

endmodule

>>> rtl/pcb_axis.sv
// One axis: subtract origin, scale by reciprocal cell length, clamp and flag halo.
module pcb_axis (
	input  logic                       clk,
	input  pcb_pkg::pipe_en_t          en,
	input  logic [pcb_pkg::POS_W-1:0]  pos,
	input  logic [pcb_pkg::POS_W-1:0]  origin,
	input  logic [pcb_pkg::POS_W-1:0]  inv_len,
	input  logic [pcb_pkg::CELL_W-1:0] cnt,
	input  logic [pcb_pkg::HALO_W-1:0] halo,
	output logic [pcb_pkg::CELL_W-1:0] cell_s3,
	output logic                       clamp_s3,
	output logic                       halo_s3
);

	logic [pcb_pkg::POS_W:0]       diff_s1;
	logic [2*pcb_pkg::POS_W-1:0]   prod;
	logic [pcb_pkg::POS_W-1:0]     hi_s2;
	logic                          neg_s2;
	logic                          negclamp_s2;
	logic [pcb_pkg::CELL_W-1:0]    top_cell;
	logic [pcb_pkg::CELL_W-1:0]    cell_c;
	logic                          clamp_c;
	logic [pcb_pkg::CELL_W:0]      upper_sum;

	// Stage 1: exact signed difference
	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_s1 <= {pos[pcb_pkg::POS_W-1], pos} - {origin[pcb_pkg::POS_W-1], origin};
		end
	end

	// Stage 2: Q16.16 by Q16.16, keep the integer part
	assign prod = {{pcb_pkg::POS_W{1'b0}}, diff_s1[pcb_pkg::POS_W-1:0]}
		* {{pcb_pkg::POS_W{1'b0}}, inv_len};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hi_s2       <= prod[2*pcb_pkg::POS_W-1:pcb_pkg::POS_W];
			neg_s2      <= diff_s1[pcb_pkg::POS_W];
			negclamp_s2 <= diff_s1[pcb_pkg::POS_W] && (inv_len != '0);
		end
	end

	// Stage 3: clamp into the grid and test the halo layer
	assign top_cell = cnt - pcb_pkg::CELL_W'(1);

	always_comb begin
		if (neg_s2) begin
			cell_c  = '0;
			clamp_c = negclamp_s2;
		end else if (hi_s2 > {{(pcb_pkg::POS_W-pcb_pkg::CELL_W){1'b0}}, top_cell}) begin
			cell_c  = top_cell;
			clamp_c = 1'b1;
		end else begin
			cell_c  = hi_s2[pcb_pkg::CELL_W-1:0];
			clamp_c = 1'b0;
		end
	end

	assign upper_sum = {1'b0, cell_c} + {{(pcb_pkg::CELL_W+1-pcb_pkg::HALO_W){1'b0}}, halo};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			cell_s3  <= cell_c;
			clamp_s3 <= clamp_c;
			halo_s3  <= ({1'b0, cell_c} < {{(pcb_pkg::CELL_W+1-pcb_pkg::HALO_W){1'b0}}, halo})
				|| (upper_sum >= {1'b0, cnt});
		end
	end

endmodule

>>> rtl/pcb_linear.sv
// Linear cell index z*ny*nx + y*nx + x over two multiply stages.
module pcb_linear (
	input  logic                       clk,
	input  pcb_pkg::pipe_en_t          en,
	input  logic [pcb_pkg::CELL_W-1:0] nx,
	input  logic [pcb_pkg::CELL_W-1:0] ny,
	input  logic [pcb_pkg::CELL_W-1:0] cx_s3,
	input  logic [pcb_pkg::CELL_W-1:0] cy_s3,
	input  logic [pcb_pkg::CELL_W-1:0] cz_s3,
	input  logic                       halo_s3,
	input  logic                       clamp_s3,
	output logic [pcb_pkg::LIN_W-1:0]  lin_s5,
	output logic [pcb_pkg::CELL_W-1:0] cx_s5,
	output logic [pcb_pkg::CELL_W-1:0] cy_s5,
	output logic [pcb_pkg::CELL_W-1:0] cz_s5,
	output logic                       halo_s5,
	output logic                       clamp_s5
);

	localparam int unsigned ROW_W = 2 * pcb_pkg::CELL_W;

	logic [ROW_W-1:0]            row_s4;
	logic [pcb_pkg::CELL_W-1:0]  cx_s4;
	logic [pcb_pkg::CELL_W-1:0]  cy_s4;
	logic [pcb_pkg::CELL_W-1:0]  cz_s4;
	logic                        halo_s4;
	logic                        clamp_s4;
	logic [ROW_W-1:0]            zy_prod;
	logic [pcb_pkg::LIN_W-1:0]   full_prod;
	logic [pcb_pkg::LIN_W:0]     lin_sum;

	// Stage 4: z*ny + y
	assign zy_prod = {{pcb_pkg::CELL_W{1'b0}}, cz_s3} * {{pcb_pkg::CELL_W{1'b0}}, ny};

	always_ff @(posedge clk) begin
		if (en.s4) begin
			row_s4   <= zy_prod + {{pcb_pkg::CELL_W{1'b0}}, cy_s3};
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;
			cz_s4    <= cz_s3;
			halo_s4  <= halo_s3;
			clamp_s4 <= clamp_s3;
		end
	end

	// Stage 5: row*nx + x
	assign full_prod = {{pcb_pkg::CELL_W{1'b0}}, row_s4}
		* {{ROW_W{1'b0}}, nx};
	assign lin_sum = {1'b0, full_prod} + {{(pcb_pkg::LIN_W+1-pcb_pkg::CELL_W){1'b0}}, cx_s4};

	always_ff @(posedge clk) begin
		if (en.s5) begin
			lin_s5   <= lin_sum[pcb_pkg::LIN_W-1:0];
			cx_s5    <= cx_s4;
			cy_s5    <= cy_s4;
			cz_s5    <= cz_s4;
			halo_s5  <= halo_s4;
			clamp_s5 <= clamp_s4;
		end
	end

endmodule

>>> rtl/point_to_cell_binning.sv
// With the skid buffer empty, an accepted item enters stage s1 and passes s2 to s5 in order; out_valid is valid_s5.
// Throughput: one item per cycle unless out_stall holds; a stage advances when empty or when the next stage moves.
// The input skid buffer drives a registered in_stall and holds one item while the output stalls.
// Reset clears the stage valid bits, the skid buffer flag and every configuration register
// to its reset value; pipeline payload registers are not reset.
module point_to_cell_binning #(
	parameter int unsigned AXIS_CELLS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [pcb_pkg::IDX_W-1:0]   wr_index,
	input  logic [pcb_pkg::POS_W-1:0]   wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic signed [31:0]          pos_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [29:0]                 linear_cell,
	output logic [9:0]                  cell_x,
	output logic [9:0]                  cell_y,
	output logic [9:0]                  cell_z,
	output logic                        in_halo,
	output logic                        was_clamped
);

	localparam logic [pcb_pkg::LIMIT_W-1:0] CELL_LIMIT = pcb_pkg::LIMIT_W'(AXIS_CELLS);

	logic [pcb_pkg::POS_W-1:0]  origin_x_q, origin_y_q, origin_z_q;
	logic [pcb_pkg::POS_W-1:0]  inv_x_q, inv_y_q, inv_z_q;
	logic [pcb_pkg::DIMS_W-1:0] dims_q;
	logic [pcb_pkg::HALO_W-1:0] halo_q;

	logic [pcb_pkg::CELL_W-1:0] nx, ny, nz;
	logic                       sk_valid;
	logic [pcb_pkg::ITEM_W-1:0] sk_data;
	logic                       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	pcb_pkg::pipe_en_t          en;

	logic [pcb_pkg::CELL_W-1:0] cx_s3, cy_s3, cz_s3;
	logic                       clx_s3, cly_s3, clz_s3;
	logic                       hx_s3, hy_s3, hz_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= pcb_pkg::RST_ORIGIN;
			origin_y_q <= pcb_pkg::RST_ORIGIN;
			origin_z_q <= pcb_pkg::RST_ORIGIN;
			inv_x_q    <= pcb_pkg::RST_INV;
			inv_y_q    <= pcb_pkg::RST_INV;
			inv_z_q    <= pcb_pkg::RST_INV;
			dims_q     <= pcb_pkg::RST_DIMS;
			halo_q     <= pcb_pkg::RST_HALO;
		end else if (wr_en) begin
			case (wr_index)
				pcb_pkg::REG_ORIGIN_X:  origin_x_q <= wr_data;
				pcb_pkg::REG_ORIGIN_Y:  origin_y_q <= wr_data;
				pcb_pkg::REG_ORIGIN_Z:  origin_z_q <= wr_data;
				pcb_pkg::REG_INV_LEN_X: inv_x_q    <= wr_data;
				pcb_pkg::REG_INV_LEN_Y: inv_y_q    <= wr_data;
				pcb_pkg::REG_INV_LEN_Z: inv_z_q    <= wr_data;
				pcb_pkg::REG_GRID_DIMS: dims_q     <= wr_data[pcb_pkg::DIMS_W-1:0];
				pcb_pkg::REG_HALO:      halo_q     <= wr_data[pcb_pkg::HALO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective cell counts per axis
	assign nx = pcb_pkg::axis_count(dims_q[9:0],   CELL_LIMIT);
	assign ny = pcb_pkg::axis_count(dims_q[19:10], CELL_LIMIT);
	assign nz = pcb_pkg::axis_count(dims_q[29:20], CELL_LIMIT);

	// Advance a stage when it is empty or the next one moves
	assign en.s5 = !valid_s5 || !out_stall;
	assign en.s4 = !valid_s4 || en.s5;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	pcb_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   ({pos_z, pos_y, pos_x}),
		.out_valid (sk_valid),
		.out_stall (!en.s1),
		.out_data  (sk_data)
	);

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= sk_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	pcb_axis u_axis_x (
		.clk      (clk),
		.en       (en),
		.pos      (sk_data[31:0]),
		.origin   (origin_x_q),
		.inv_len  (inv_x_q),
		.cnt      (nx),
		.halo     (halo_q),
		.cell_s3  (cx_s3),
		.clamp_s3 (clx_s3),
		.halo_s3  (hx_s3)
	);

	pcb_axis u_axis_y (
		.clk      (clk),
		.en       (en),
		.pos      (sk_data[63:32]),
		.origin   (origin_y_q),
		.inv_len  (inv_y_q),
		.cnt      (ny),
		.halo     (halo_q),
		.cell_s3  (cy_s3),
		.clamp_s3 (cly_s3),
		.halo_s3  (hy_s3)
	);

	pcb_axis u_axis_z (
		.clk      (clk),
		.en       (en),
		.pos      (sk_data[95:64]),
		.origin   (origin_z_q),
		.inv_len  (inv_z_q),
		.cnt      (nz),
		.halo     (halo_q),
		.cell_s3  (cz_s3),
		.clamp_s3 (clz_s3),
		.halo_s3  (hz_s3)
	);

	pcb_linear u_linear (
		.clk      (clk),
		.en       (en),
		.nx       (nx),
		.ny       (ny),
		.cx_s3    (cx_s3),
		.cy_s3    (cy_s3),
		.cz_s3    (cz_s3),
		.halo_s3  (hx_s3 | hy_s3 | hz_s3),
		.clamp_s3 (clx_s3 | cly_s3 | clz_s3),
		.lin_s5   (linear_cell),
		.cx_s5    (cell_x),
		.cy_s5    (cell_y),
		.cz_s5    (cell_z),
		.halo_s5  (in_halo),
		.clamp_s5 (was_clamped)
	);

	assign out_valid = valid_s5;

endmodule

>>> rtl/pcb_checker.sv
// Port-level checks for the point-to-cell binning block, bound to the top level.
module pcb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [29:0] linear_cell,
	input logic [9:0]  cell_x,
	input logic [9:0]  cell_y,
	input logic [9:0]  cell_z,
	input logic        in_halo,
	input logic        was_clamped
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({linear_cell, cell_x, cell_y, cell_z, in_halo, was_clamped}))
		else $error("stalled result changed or dropped");

	// The skid buffer fills only from an offered item
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall raised with no item offered");

	// Input stalls only when the whole pipeline is full and a result waits
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while no result is pending");

	// A full skid buffer drains only once the output moves
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_stall |=> in_stall)
		else $error("skid buffer released while output stalled");

endmodule

bind point_to_cell_binning pcb_checker u_pcb_checker (.*);
